// ===== rtl/rational_arith_gcd_reduce_defines.svh =====
// assertion macros for the rational arithmetic block
`ifndef RATIONAL_ARITH_GCD_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_GCD_REDUCE_DEFINES_SVH

// implication check, sampled on the rising clock edge, disabled during reset
`define RAG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication check
`define RAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rag_pkg.sv =====
// shared types and constants for the rational arithmetic block
package rag_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned WideWidth = 2 * DataWidth + 1;
  localparam int unsigned CntWidth  = $clog2(WideWidth + 1);

  localparam logic [2:0] OpAdd = 3'd0;
  localparam logic [2:0] OpSub = 3'd1;
  localparam logic [2:0] OpMul = 3'd2;
  localparam logic [2:0] OpDiv = 3'd3;
  localparam logic [2:0] OpNeg = 3'd4;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusDivZ = 2'd1;
  localparam logic [1:0] StatusOvf  = 2'd2;

  typedef logic [WideWidth-1:0] wide_t;

  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StMul3, StSum, StGcdInit, StGcdTwo, StGcdU,
    StGcdV, StGcdSub, StDivStart, StDivWait, StCheck, StDone
  } state_e;

  typedef struct packed {
    logic  start;
    wide_t dividend;
    wide_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  busy;
    wide_t quotient;
  } div_rsp_t;
endpackage

// ===== rtl/rag_divider.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
module rag_divider import rag_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  wide_t               quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [WideWidth:0]  trial;
  wide_t               shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    shifted = {rem_q[WideWidth-2:0], quo_q[WideWidth-1]};
    trial   = {1'b0, shifted} - {1'b0, den_q};
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(WideWidth);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // quotient bits enter at the bottom as dividend bits leave at the top
      if (!trial[WideWidth]) begin
        rem_d = trial[WideWidth-1:0];
        quo_d = {quo_q[WideWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[WideWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== rtl/rational_arith_gcd_reduce.sv =====
// top level: rational add, subtract, multiply, divide and negate with gcd reduction
//
//  channel  ports                                   transfer
//  command  start_i, op_i, a_num_i .. b_den_i       start_i high while busy_o low
//  result   done_o, res_num_o, res_den_o, status_o  done_o high, one cycle
//
// one item passes setup and checks, a binary gcd loop (common and single factors of two
// shifted out, then a v-halving state and a subtract state per loop pass) and two
// divider runs (start, quotient bits of the 65-bit word, done), one for the numerator
// and one for the denominator; the gcd loop and the serial divider take most of the time
// a zero denominator or divisor is caught at once, in StMul1, which goes straight to StDone
// reset is asynchronous, active low, and clears only control state
// the receiver cannot stall: a result is shown for one cycle only
`include "rational_arith_gcd_reduce_defines.svh"
module rational_arith_gcd_reduce import rag_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  op_i,
  input  logic signed [DataWidth-1:0] a_num_i,
  input  logic signed [DataWidth-1:0] a_den_i,
  input  logic signed [DataWidth-1:0] b_num_i,
  input  logic signed [DataWidth-1:0] b_den_i,
  output logic                        done_o,
  output logic signed [DataWidth-1:0] res_num_o,
  output logic [DataWidth-2:0]        res_den_o,
  output logic [1:0]                  status_o
);
  localparam int unsigned MagWidth = DataWidth;
  localparam logic [MagWidth-1:0] Half = {1'b1, {(MagWidth-1){1'b0}}};

  state_e state_q, state_d;

  // operand magnitudes and signs captured at the transfer
  logic [MagWidth-1:0] am_q, adm_q, bm_q, bdm_q;
  logic                an_q, adn_q, bn_q, bdn_q;
  logic [2:0]          op_q;

  // wide working registers: numerator, denominator, cross product, gcd pair
  wide_t num_q, num_d, den_q, den_d, p_q, p_d, u_q, u_d, v_q, v_d;
  logic  pn_q, pn_d, nn_q, nn_d, dn_q, dn_d;
  logic [CntWidth-1:0] k_q, k_d;
  logic  phase_q, phase_d;

  logic                 done_q, done_d;
  logic [DataWidth-1:0] rnum_q, rnum_d;
  logic [DataWidth-2:0] rden_q, rden_d;
  logic [1:0]           stat_q, stat_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // shared multiplier, one 32x32 product per cycle
  logic [MagWidth-1:0]   mul_a, mul_b;
  logic [2*MagWidth-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared subtractor for the gcd loop and the signed sum
  wide_t sub_x, sub_y, sub_r;
  assign sub_r = sub_x - sub_y;

  function automatic logic [MagWidth-1:0] mag(input logic [DataWidth-1:0] v);
    return v[DataWidth-1] ? MagWidth'(-v) : v;
  endfunction

  logic qn, neg, is_neg_op;
  assign is_neg_op = (op_q > OpDiv);
  assign neg = nn_q ^ dn_q;

  always_comb begin
    state_d = state_q;
    num_d = num_q; den_d = den_q; p_d = p_q; pn_d = pn_q;
    u_d = u_q; v_d = v_q; k_d = k_q; phase_d = phase_q;
    nn_d = nn_q; dn_d = dn_q;
    done_d = 1'b0;
    rnum_d = rnum_q; rden_d = rden_q; stat_d = stat_q;
    mul_a = am_q; mul_b = bdm_q;
    sub_x = u_q; sub_y = v_q;
    qn = (bn_q ^ adn_q) ^ (op_q == OpSub);
    div_req.start    = 1'b0;
    div_req.dividend = num_q;
    div_req.divisor  = u_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StMul1;
        end
      end
      StMul1: begin
        if (bdm_q == '0 || (!is_neg_op && (adm_q == '0 ||
            (op_q == OpDiv && bm_q == '0)))) begin
          stat_d = StatusDivZ; rnum_d = '0; rden_d = '0;
          state_d = StDone;
        end else if (is_neg_op) begin
          num_d = WideWidth'(bm_q); nn_d = !bn_q;
          den_d = WideWidth'(bdm_q); dn_d = bdn_q;
          state_d = StGcdInit;
        end else begin
          // denominator product first: a_den*b_den, or a_den*b_num for divide
          mul_a = adm_q;
          mul_b = (op_q == OpDiv) ? bm_q : bdm_q;
          den_d = WideWidth'(mul_p);
          dn_d  = adn_q ^ ((op_q == OpDiv) ? bn_q : bdn_q);
          state_d = StMul2;
        end
      end
      StMul2: begin
        mul_a = am_q;
        mul_b = (op_q == OpMul) ? bm_q : bdm_q;
        p_d  = WideWidth'(mul_p);
        pn_d = an_q ^ ((op_q == OpMul) ? bn_q : bdn_q);
        if (op_q == OpMul || op_q == OpDiv) begin
          num_d = WideWidth'(mul_p); nn_d = pn_d;
          state_d = StGcdInit;
        end else begin
          state_d = StMul3;
        end
      end
      StMul3: begin
        mul_a = bm_q; mul_b = adm_q;
        num_d = WideWidth'(mul_p);
        state_d = StSum;
      end
      StSum: begin
        // signed sum of p and q (q held in num)
        if (pn_q == qn) begin
          num_d = p_q + num_q; nn_d = pn_q;
        end else if (p_q >= num_q) begin
          sub_x = p_q; sub_y = num_q;
          num_d = sub_r; nn_d = pn_q;
        end else begin
          sub_x = num_q; sub_y = p_q;
          num_d = sub_r; nn_d = qn;
        end
        state_d = StGcdInit;
      end
      StGcdInit: begin
        if (num_q == '0) begin
          num_d = '0; den_d = WideWidth'(1); nn_d = 1'b0; dn_d = 1'b0;
          state_d = StCheck;
        end else begin
          u_d = num_q; v_d = den_q; k_d = '0;
          state_d = StGcdTwo;
        end
      end
      StGcdTwo: begin
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1; v_d = v_q >> 1; k_d = k_q + 1'b1;
        end else begin
          state_d = StGcdU;
        end
      end
      StGcdU: begin
        if (!u_q[0]) u_d = u_q >> 1;
        else state_d = StGcdV;
      end
      StGcdV: begin
        if (!v_q[0]) v_d = v_q >> 1;
        else state_d = StGcdSub;
      end
      StGcdSub: begin
        // u keeps the smaller, v takes the difference
        if (u_q > v_q) begin
          sub_x = u_q; sub_y = v_q; u_d = v_q;
        end else begin
          sub_x = v_q; sub_y = u_q;
        end
        v_d = sub_r;
        if (sub_r == '0) begin
          u_d = (u_q > v_q ? v_q : u_q) << k_q;
          phase_d = 1'b0;
          state_d = StDivStart;
        end else begin
          state_d = StGcdV;
        end
      end
      StDivStart: begin
        div_req.start    = 1'b1;
        div_req.dividend = phase_q ? den_q : num_q;
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_rsp.done) begin
          if (!phase_q) begin
            num_d = div_rsp.quotient; phase_d = 1'b1;
            state_d = StDivStart;
          end else begin
            den_d = div_rsp.quotient;
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        rnum_d = '0; rden_d = '0;
        if (den_q == '0) begin
          stat_d = StatusDivZ;
        end else if (num_q[WideWidth-1:MagWidth] != '0 ||
                     num_q[MagWidth-1:0] > (neg ? Half : Half - 1'b1) ||
                     den_q[WideWidth-1:MagWidth-1] != '0) begin
          stat_d = StatusOvf;
        end else begin
          stat_d = StatusOk;
          rnum_d = neg ? DataWidth'(-num_q[MagWidth-1:0]) : num_q[DataWidth-1:0];
          rden_d = den_q[DataWidth-2:0];
        end
        state_d = StDone;
      end
      StDone: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  rag_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      op_q <= op_i;
      am_q <= mag(a_num_i);  an_q  <= a_num_i[DataWidth-1];
      adm_q <= mag(a_den_i); adn_q <= a_den_i[DataWidth-1];
      bm_q <= mag(b_num_i);  bn_q  <= b_num_i[DataWidth-1];
      bdm_q <= mag(b_den_i); bdn_q <= b_den_i[DataWidth-1];
    end
    num_q <= num_d; den_q <= den_d; p_q <= p_d; pn_q <= pn_d;
    u_q <= u_d; v_q <= v_d; k_q <= k_d; phase_q <= phase_d;
    nn_q <= nn_d; dn_q <= dn_d;
    rnum_q <= rnum_d; rden_q <= rden_d; stat_q <= stat_d;
  end

  assign busy_o    = (state_q != StIdle);
  assign done_o    = done_q;
  assign res_num_o = rnum_q;
  assign res_den_o = rden_q;
  assign status_o  = stat_q;

  `RAG_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `RAG_ASSERT_NEXT(a_done_one, clk_i, rst_ni, done_o, !done_o)
  `RAG_ASSERT_IMP(a_ok_den, clk_i, rst_ni, done_o && status_o == StatusOk, res_den_o != '0)
  `RAG_ASSERT_IMP(a_err_zero, clk_i, rst_ni, done_o && status_o != StatusOk,
    res_num_o == '0 && res_den_o == '0)
  `RAG_ASSERT_IMP(a_div_idle, clk_i, rst_ni, div_rsp.busy, state_q == StDivWait)
endmodule

// ===== tb/sv/rational_arith_gcd_reduce_tb.sv =====
// testbench for the rational arithmetic block with gcd reduction
module rational_arith_gcd_reduce_tb;
  import rag_pkg::*;

  localparam int unsigned NumRandom = 1930;
  localparam int unsigned IdleLimit = 5000;

  typedef logic [127:0] mag_t;

  typedef struct {
    logic signed [DataWidth-1:0] num;
    logic [DataWidth-2:0]        den;
    logic [1:0]                  status;
  } quotient_t;

  // gcd of two magnitudes by repeated halving and subtraction, a zero one returning the other
  function automatic mag_t stein_gcd(mag_t u, mag_t v);
    int   twos;
    mag_t t;
    twos = 0;
    if (u == 0) return v;
    if (v == 0) return u;
    while (((u | v) & 1) == 0) begin
      u = u >> 1;
      v = v >> 1;
      twos++;
    end
    while ((u & 1) == 0) u = u >> 1;
    do begin
      while ((v & 1) == 0) v = v >> 1;
      if (u > v) begin
        t = u;
        u = v;
        v = t;
      end
      v = v - u;
    end while (v != 0);
    return u << twos;
  endfunction

  function automatic logic [63:0] magnitude(logic [DataWidth-1:0] x);
    return x[DataWidth-1] ? 64'(DataWidth'(-x)) : 64'(x);
  endfunction

  // reduced quotient of one operation
  function automatic quotient_t reduce_fraction(logic [2:0] op, logic [31:0] an,
                                               logic [31:0] ad, logic [31:0] bn,
                                               logic [31:0] bd);
    quotient_t   r;
    mag_t        nm, dm, p, q, g;
    logic        nneg, dneg, pneg, qneg, neg;
    logic [63:0] am, adm, bm, bdm, half;
    r = '{num: '0, den: '0, status: StatusOk};
    am = magnitude(an);
    adm = magnitude(ad);
    bm = magnitude(bn);
    bdm = magnitude(bd);
    half = 64'd1 << (DataWidth - 1);
    if (op > OpDiv) begin
      if (bdm == 0) begin
        r.status = StatusDivZ;
        return r;
      end
      nm = bm;
      nneg = !bn[31];
      dm = bdm;
      dneg = bd[31];
    end else begin
      if (adm == 0 || bdm == 0 || (op == OpDiv && bm == 0)) begin
        r.status = StatusDivZ;
        return r;
      end
      case (op)
        OpMul: begin
          nm = am * bm;
          nneg = an[31] != bn[31];
          dm = adm * bdm;
          dneg = ad[31] != bd[31];
        end
        OpDiv: begin
          nm = am * bdm;
          nneg = an[31] != bd[31];
          dm = adm * bm;
          dneg = ad[31] != bn[31];
        end
        default: begin
          p = am * bdm;
          q = bm * adm;
          pneg = an[31] != bd[31];
          qneg = (bn[31] != ad[31]) ^ (op == OpSub);
          // signed sum of the two cross products
          if (pneg == qneg) begin
            nm = p + q;
            nneg = pneg;
          end else if (p >= q) begin
            nm = p - q;
            nneg = pneg;
          end else begin
            nm = q - p;
            nneg = qneg;
          end
          dm = adm * bdm;
          dneg = ad[31] != bd[31];
        end
      endcase
    end
    neg = nneg != dneg;
    if (nm == 0) begin
      dm = 1;
      neg = 1'b0;
    end else begin
      g = stein_gcd(nm, dm);
      nm = nm / g;
      dm = dm / g;
    end
    if (nm > (neg ? half : half - 1) || dm > half - 1) begin
      r.status = StatusOvf;
      return r;
    end
    r.num = neg ? -nm[DataWidth-1:0] : nm[DataWidth-1:0];
    r.den = dm[DataWidth-2:0];
    return r;
  endfunction

  class fraction_scoreboard;
    quotient_t pending[$];
    int        errors;
    int        matched;

    function void note_command(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
      pending.push_back(reduce_fraction(op, an, ad, bn, bd));
    endfunction

    function void check_result(logic [31:0] num, logic [30:0] den, logic [1:0] st);
      quotient_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding num %0d den %0d status %0d",
                 $time, $signed(num), den, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (num !== e.num) begin
        $display("%0t: res_num expected %0d actual %0d", $time, e.num, $signed(num));
        errors++;
      end
      if (den !== e.den) begin
        $display("%0t: res_den expected %0d actual %0d", $time, e.den, den);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [2:0]                  op_i = '0;
  logic signed [DataWidth-1:0] a_num_i = '0;
  logic signed [DataWidth-1:0] a_den_i = '0;
  logic signed [DataWidth-1:0] b_num_i = '0;
  logic signed [DataWidth-1:0] b_den_i = '0;
  logic                        done_o;
  logic signed [DataWidth-1:0] res_num_o;
  logic [DataWidth-2:0]        res_den_o;
  logic [1:0]                  status_o;

  fraction_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;

  rational_arith_gcd_reduce dut (.*);

  always #10 clk_i = ~clk_i;

  // result side: the block shows each result for one cycle only
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_num_o, res_den_o, status_o);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one command transfer, then a random idle gap, which may be empty
  task automatic send_command(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 9);
    start_i <= 1'b1;
    op_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(op, an, ad, bn, bd);
    sent++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly small operands so reduction does real work, with full-range ones mixed in
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      2:       return 32'($signed($urandom_range(0, 40)) - 20);
      3:       return $urandom() & 32'h0000_ffff;
      4:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return ($urandom() & 32'h3ff) << $urandom_range(0, 21);
    endcase
  endfunction

  initial begin
    logic [2:0]  op;
    logic [31:0] ad, bd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, zero denominators, zero numerators, extremes
    send_command(OpAdd, 32'd1, 32'd2, 32'd1, 32'd3);
    send_command(OpSub, 32'd1, 32'd2, 32'd1, 32'd2);
    send_command(OpMul, -32'sd4, 32'd6, 32'd9, -32'sd2);
    send_command(OpDiv, 32'd3, 32'd4, -32'sd3, 32'd8);
    send_command(OpNeg, 32'd0, 32'd0, 32'd5, -32'sd10);
    send_command(3'd5, 32'd1, 32'd1, 32'h8000_0000, 32'd1);
    send_command(3'd6, 32'd1, 32'd1, 32'd7, 32'd0);
    send_command(3'd7, 32'd1, 32'd1, 32'd0, 32'h8000_0000);
    send_command(OpAdd, 32'd1, 32'd0, 32'd1, 32'd1);
    send_command(OpMul, 32'd1, 32'd1, 32'd1, 32'd0);
    send_command(OpDiv, 32'd1, 32'd1, 32'd0, 32'd5);
    send_command(OpMul, 32'd0, 32'd7, 32'd3, 32'd5);
    send_command(OpAdd, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_command(OpSub, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_command(OpMul, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_command(OpMul, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_command(OpDiv, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
    send_command(OpDiv, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff);
    send_command(OpAdd, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_command(OpSub, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      op = 3'($urandom_range(0, 7));
      ad = pick_operand();
      bd = pick_operand();
      // zero denominators only now and then
      if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
      if (bd == 0 && $urandom_range(0, 3) != 0) bd = 1;
      send_command(op, pick_operand(), ad, pick_operand(), bd);
      if (i % 400 == 399) drain_results();
    end

    drain_results();
    repeat (400) @(posedge clk_i);
    $display("covered %0d commands over all op codes, zero and extreme operands",
             sent);
    $display("%0d results checked", sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
